// ===== design/ss_pkg.sv =====
// ----------------------------------------------------------------------------
// ss_pkg - shared types and constants for the substring search block
// Register map codes, configuration port widths, the cell control bundle
// and the ASCII case fold.
// ----------------------------------------------------------------------------
package ss_pkg;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // register index, taken from paddr[4:3] (8-byte stride)
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_IGNORE_CASE    = 2'd2,
        REG_UNUSED         = 2'd3
    } ss_reg_idx_t;

    localparam int PATTERN_W = 64;
    localparam int LENGTH_W  = 4;
    localparam int OFFSET_W  = 16;

    // per-cell control from the top level
    typedef struct packed {
        logic [7:0] pattern_byte;
        logic       enable;
        logic       ignore_case;
    } ss_cell_ctrl_t;

    // fold 'A'..'Z' to lower case when enabled
    function automatic logic [7:0] ss_fold(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5a)) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== design/ss_cell.sv =====
// ----------------------------------------------------------------------------
// ss_cell - one window cell
// Holds one text byte, hands it to the next cell on each transaction and
// compares the byte it is loading against its assigned pattern byte.
// ----------------------------------------------------------------------------
module ss_cell (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [7:0]            byte_in,
    input  ss_pkg::ss_cell_ctrl_t ctrl,
    output logic [7:0]            byte_out,
    output logic                  hit
);
    import ss_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? byte_in : byte_reg;

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

    // disabled cells never veto a match
    assign hit = !ctrl.enable ||
                 (ss_fold(ctrl.pattern_byte, ctrl.ignore_case) ==
                  ss_fold(byte_in, ctrl.ignore_case));

endmodule

// ===== design/substring_search.sv =====
// ----------------------------------------------------------------------------
// substring_search - streaming first-occurrence search for a short pattern
// Text bytes stream through a row of window cells; each cell compares its
// byte with one pattern byte and the top level latches the first match.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per transaction in s_tdata, s_tlast marks the
//   final byte of a text. m_ channel: one result per text, issued for the
//   s_tlast byte; m_tuser = found, m_tdata = offset of the first match start
//   (zero when nothing was found). An empty pattern reports found at 0.
//   The APB port writes pattern bytes (0x00), length (0x08) and case mode
//   (0x10); write it only while no text is in flight.
// Result: registered, valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle while s_tready is high, set by the
//   combinational compare over the cell row; texts may follow with no gap.
// Stall: the result sits in an output register. While it waits, a new byte
//   is still accepted in the cycle m_tready returns high; s_tready drops only
//   while a result is held and m_tready is low.
// Reset: synchronous, active low. Clears registers, the position count, the
//   match flag and the result valid. After each final byte the search state
//   returns to that cleared state; register values are kept.
// Matches starting at or beyond MAX_TEXT (or above 65535) are not reported,
//   and the position count saturates at MAX_TEXT + MAX_PATTERN.
// ----------------------------------------------------------------------------
module substring_search #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // end_of_text
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ss_pkg::OFFSET_W-1:0]    m_tdata,   // [15:0] match_offset
    output logic                           m_tuser,   // [0] found
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ss_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ss_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ss_pkg::APB_DATA_W-1:0]  prdata,
    output logic                           pready
);
    import ss_pkg::*;

    localparam int POS_CAP   = MAX_TEXT + MAX_PATTERN;
    localparam int PW        = $clog2(POS_CAP + 1);
    localparam int OFF_LIMIT = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;

    // ---------------- configuration registers ----------------
    logic [PATTERN_W-1:0] pattern_reg,  pattern_next;
    logic [LENGTH_W-1:0]  length_reg,   length_next;
    logic                 icase_reg,    icase_next;

    ss_reg_idx_t reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = ss_reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        icase_next   = icase_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_PATTERN_BYTES:  pattern_next = pwdata[PATTERN_W-1:0];
                REG_PATTERN_LENGTH: length_next  = pwdata[LENGTH_W-1:0];
                REG_IGNORE_CASE:    icase_next   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_BYTES:  prdata = pattern_reg;
            REG_PATTERN_LENGTH: prdata = {{(APB_DATA_W-LENGTH_W){1'b0}}, length_reg};
            REG_IGNORE_CASE:    prdata = {{(APB_DATA_W-1){1'b0}}, icase_reg};
            default:            prdata = '0;
        endcase
    end

    // effective length: clamp to the cell count
    logic [LENGTH_W-1:0] eff_len;
    assign eff_len = (length_reg > LENGTH_W'(MAX_PATTERN)) ? LENGTH_W'(MAX_PATTERN)
                                                            : length_reg;

    // ---------------- cell row ----------------
    logic                  accept;
    logic [7:0]            cell_in  [MAX_PATTERN];
    logic [7:0]            cell_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_hit;
    ss_cell_ctrl_t         cell_ctrl [MAX_PATTERN];

    assign accept = s_tvalid && s_tready;

    // cell i loads the byte that arrived i transactions ago; it is checked
    // against pattern byte (len - 1 - i)
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            cell_ctrl[i].pattern_byte = 8'h00;
            cell_ctrl[i].enable       = (LENGTH_W'(i) < eff_len);
            cell_ctrl[i].ignore_case  = icase_reg;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if ((LENGTH_W'(i + j + 1)) == eff_len) begin
                    cell_ctrl[i].pattern_byte = pattern_reg[8*j +: 8];
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_in[g] = s_tdata;
        end else begin : g_link
            assign cell_in[g] = cell_out[g-1];
        end
        ss_cell u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .byte_in  (cell_in[g]),
            .ctrl     (cell_ctrl[g]),
            .byte_out (cell_out[g]),
            .hit      (cell_hit[g])
        );
    end

    // ---------------- match tracking ----------------
    logic [PW-1:0]       pos_reg,  pos_next;
    logic                seen_reg, seen_next;
    logic [OFFSET_W-1:0] off_reg,  off_next;

    logic                pos_run;
    logic [PW-1:0]       pos_inc;
    logic [PW-1:0]       start;
    logic                new_hit;
    logic                seen_after;
    logic [OFFSET_W-1:0] off_after;

    assign pos_run = pos_reg < PW'(POS_CAP);
    assign pos_inc = pos_reg + PW'(1);
    assign start   = pos_inc - PW'(eff_len);
    assign new_hit = pos_run && (eff_len != '0) && !seen_reg &&
                     (pos_inc >= PW'(eff_len)) && (&cell_hit) &&
                     (start < PW'(OFF_LIMIT));

    assign seen_after = seen_reg || new_hit;
    assign off_after  = new_hit ? OFFSET_W'(start) : off_reg;

    always_comb begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        off_next  = off_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next  = '0;
                seen_next = 1'b0;
                off_next  = '0;
            end else begin
                pos_next  = pos_run ? pos_inc : pos_reg;
                seen_next = seen_after;
                off_next  = off_after;
            end
        end
    end

    // ---------------- output register ----------------
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [OFFSET_W-1:0] m_off_reg,   m_off_next;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_off_next   = m_off_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_tlast) begin
            m_valid_next = 1'b1;
            if (eff_len == '0) begin
                m_found_next = 1'b1;
                m_off_next   = '0;
            end else begin
                m_found_next = seen_after;
                m_off_next   = seen_after ? off_after : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
            icase_reg   <= 1'b0;
            pos_reg     <= '0;
            seen_reg    <= 1'b0;
            off_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            icase_reg   <= icase_next;
            pos_reg     <= pos_next;
            seen_reg    <= seen_next;
            off_reg     <= off_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_off_reg   <= m_off_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_off_reg;

endmodule

// ===== design/ss_checker.sv =====
// ----------------------------------------------------------------------------
// ss_checker - port-level checks for substring_search
// Watches the stream ports for result timing and consistency.
// ----------------------------------------------------------------------------
module ss_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ss_pkg::OFFSET_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import ss_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // final byte gives a result on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after final byte");

    // a new result only follows a final byte
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without final byte");

    // not found reports offset zero
    a_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-zero offset without a match");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind substring_search ss_checker u_ss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/substring_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_test - self-checking bench for the streaming substring search
// Text bytes go in over the s_ stream and one found/offset result per text
// comes back on the m_ stream. A behavioural search model in the bench
// predicts every random result, and results are checked in order. A short
// directed table with typed results covers the corner cases. Random texts
// follow, many of them carrying the pattern or only its head.
// ----------------------------------------------------------------------------
module substring_search_test;
    import ss_pkg::*;

    localparam int MAX_PATTERN   = 8;
    localparam int MAX_TEXT      = 65536;
    localparam int POS_CAP       = MAX_TEXT + MAX_PATTERN;
    localparam int SETTLE_CYCLES = 4;          // result lands in the cycle after tlast is accepted
    localparam int RANDOM_ITEMS  = 700;
    localparam int QUIET_FROM    = 600;        // no idling past this many random bytes
    localparam int TIMEOUT_NS    = 4_000_000;  // several times the worst run
    localparam int DIRECTED_ROWS = 30;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } search_result_t;

    // directed table row: a register write, a plain text byte, or a final
    // byte whose result is typed in below
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BYTE,
        ROW_FINAL
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        ss_reg_idx_t         reg_idx;
        logic [63:0]         value;
        logic [7:0]          data;
        logic                exp_found;
        logic [OFFSET_W-1:0] exp_offset;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  s_tlast;   // end_of_text
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OFFSET_W-1:0]   m_tdata;   // [15:0] match_offset
    logic                  m_tuser;   // [0] found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // travels alongside s_tdata so the monitor sees it on the accepting edge
    logic                  row_typed;
    search_result_t        row_expect;

    // search model: register copies and per-text state
    logic [63:0]           pattern_model;
    logic [3:0]            length_model;
    logic                  nocase_model;
    logic [7:0]            text_window [8];
    int unsigned           text_count;
    logic                  match_latched;
    logic [OFFSET_W-1:0]   match_start;

    search_result_t        expected_results [$];
    search_result_t        predicted;
    search_result_t        want;
    logic                  produced;

    int                    err_count;
    int                    items_sent;
    bit                    allow_idle;
    int                    gap_rate;
    int                    stall_rate;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty pattern straight after reset: found at 0
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h00, 1'b1, 16'd0},
        // all-ones pattern, overlong length clamps to eight bytes
        '{ROW_WRITE, REG_PATTERN_BYTES,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd15,                8'h00, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h7F, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'hFF, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'hFF, 1'b1, 16'd1},
        // "AZ" with junk in the unused upper bytes, caseless
        '{ROW_WRITE, REG_PATTERN_BYTES,  64'hDEAD_BEEF_1234_5A41, 8'h00, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd2,                 8'h00, 1'b0, 16'd0},
        '{ROW_WRITE, REG_IGNORE_CASE,    64'd1,                 8'h00, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h61, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h7A, 1'b1, 16'd0},
        // '@' and '[' sit either side of the letters and must not fold
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h40, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h5B, 1'b0, 16'd0},
        // exact case again: lower case copy is skipped
        '{ROW_WRITE, REG_IGNORE_CASE,    64'd0,                 8'h00, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h61, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h7A, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h41, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h5A, 1'b1, 16'd2},
        // write to the spare address leaves the registers alone
        '{ROW_WRITE, REG_UNUSED,         64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 16'd0},
        '{ROW_BYTE,  REG_UNUSED,         64'd0,                 8'h41, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h5A, 1'b1, 16'd0},
        // text shorter than the pattern
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h78, 1'b0, 16'd0},
        // pattern split over two texts: state clears at each text end
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h41, 1'b0, 16'd0},
        '{ROW_FINAL, REG_UNUSED,         64'd0,                 8'h5A, 1'b0, 16'd0}
    };

    substring_search #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // search model
    // ------------------------------------------------------------------
    function automatic logic [7:0] case_folded(input logic [7:0] b);
        if (nocase_model && b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // one text byte: shift into the window, compare the newest bytes, and on
    // the final byte hand back the result and clear for the next text
    task automatic search_byte(input logic [7:0] b, input logic last,
                               output search_result_t res, output logic done);
        int unsigned len;
        int unsigned start;
        int          j;
        logic        hit;
        len = (length_model > 4'd8) ? 8 : length_model;
        for (j = 7; j > 0; j--) begin
            text_window[j] = text_window[j-1];
        end
        text_window[0] = b;
        if (text_count < POS_CAP) begin
            text_count++;
            if (len != 0 && !match_latched && text_count >= len) begin
                start = text_count - len;
                hit   = 1'b1;
                for (j = 0; j < len; j++) begin
                    if (case_folded(pattern_model[8*j +: 8]) !=
                        case_folded(text_window[len-1-j])) begin
                        hit = 1'b0;
                    end
                end
                // starts at or past the text bound are dropped
                if (hit && start < MAX_TEXT && start <= 32'hFFFF) begin
                    match_latched = 1'b1;
                    match_start   = start[OFFSET_W-1:0];
                end
            end
        end
        res  = '0;
        done = last;
        if (last) begin
            res.found  = (len == 0) ? 1'b1 : match_latched;
            res.offset = (len == 0 || !match_latched) ? '0 : match_start;
            for (j = 0; j < 8; j++) begin
                text_window[j] = 8'h00;
            end
            text_count    = 0;
            match_latched = 1'b0;
            match_start   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: check results first, then model any accepted byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with none pending: found %0d offset %0d",
                           m_tuser, m_tdata);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_tuser);
                        err_count++;
                    end
                    if (m_tdata !== want.offset) begin
                        $error("match_offset: expected %0d, actual %0d",
                               want.offset, m_tdata);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                search_byte(s_tdata, s_tlast, predicted, produced);
                if (produced) begin
                    // typed table rows override the model's answer
                    expected_results.push_back(row_typed ? row_expect : predicted);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure in bursts
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            if (allow_idle && stall_rate != 0 && $urandom_range(0, 7) < stall_rate) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input search_result_t typed_res);
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= last;
        row_typed  <= typed;
        row_expect <= typed_res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (allow_idle && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // hold the sender until every pending result is back and the block
    // has had time to settle; registers are only written after this
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup, access, then idle so back-to-back writes never
    // drive the bus twice in the same step
    task automatic apb_write(input ss_reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES:  pattern_model = value;
            REG_PATTERN_LENGTH: length_model  = value[3:0];
            REG_IGNORE_CASE:    nocase_model  = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // text bytes biased towards a few letters and the case boundaries so
    // partial and caseless matches turn up often
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges [6] = '{8'h40, 8'h5A, 8'h5B, 8'h60, 8'h7A, 8'h7B};
        case ($urandom_range(0, 4))
            0:       return 8'h41 + 8'($urandom_range(0, 2));
            1:       return 8'h61 + 8'($urandom_range(0, 2));
            2:       return edges[$urandom_range(0, 5)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int             r;
        int             k;
        int             text_len;
        int             eff_len;
        int             plant_len;
        int             start_at;
        int             text_number;
        logic [7:0]     b;
        logic [63:0]    new_pattern;
        logic [3:0]     new_length;
        logic [63:0]    filler;
        logic [7:0]     text_bytes [$];

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        row_typed     = 1'b0;
        row_expect    = '0;
        pattern_model = '0;
        length_model  = '0;
        nocase_model  = 1'b0;
        text_count    = 0;
        match_latched = 1'b0;
        match_start   = '0;
        for (k = 0; k < 8; k++) begin
            text_window[k] = 8'h00;
        end
        err_count   = 0;
        items_sent  = 0;
        allow_idle  = 1'b1;
        gap_rate    = 2;
        stall_rate  = 2;
        text_number = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < DIRECTED_ROWS; r++) begin
            case (directed_rows[r].kind)
                ROW_WRITE: begin
                    drain_results();
                    apb_write(directed_rows[r].reg_idx, directed_rows[r].value);
                end
                ROW_BYTE: begin
                    send_byte(directed_rows[r].data, 1'b0, 1'b0, '0);
                end
                default: begin
                    send_byte(directed_rows[r].data, 1'b1, 1'b1,
                              search_result_t'{directed_rows[r].exp_found,
                                               directed_rows[r].exp_offset});
                end
            endcase
        end

        // random texts; every sixth text starts a new register setting
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            allow_idle = (items_sent < QUIET_FROM);
            if (text_number % 6 == 0) begin
                drain_results();
                for (k = 0; k < 8; k++) begin
                    new_pattern[8*k +: 8] = pick_byte();
                end
                case ($urandom_range(0, 9))
                    0:       new_length = 4'd0;
                    1:       new_length = 4'($urandom_range(9, 15));
                    2:       new_length = 4'd8;
                    default: new_length = 4'($urandom_range(1, 5));
                endcase
                filler = {$urandom, $urandom};
                apb_write(REG_PATTERN_BYTES, new_pattern);
                apb_write(REG_PATTERN_LENGTH, {filler[63:4], new_length});
                apb_write(REG_IGNORE_CASE, {filler[63:1], 1'($urandom_range(0, 1))});
                if ($urandom_range(0, 3) == 0) begin
                    apb_write(REG_UNUSED, filler);
                end
            end
            text_number++;
            // some texts run flat out on both sides
            gap_rate   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            stall_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);

            text_bytes.delete();
            text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                   : $urandom_range(1, 24);
            for (k = 0; k < text_len; k++) begin
                text_bytes.push_back(pick_byte());
            end
            eff_len = (length_model > 4'd8) ? 8 : length_model;
            if (eff_len != 0 && text_len >= eff_len && $urandom_range(0, 2) != 0) begin
                // plant the pattern, or only its head for a near miss
                plant_len = ($urandom_range(0, 3) == 0) ? eff_len - 1 : eff_len;
                start_at  = $urandom_range(0, text_len - eff_len);
                for (k = 0; k < plant_len; k++) begin
                    b = pattern_model[8*k +: 8];
                    if (nocase_model && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A
                        && $urandom_range(0, 1) == 1) begin
                        b = b ^ 8'h20;
                    end
                    text_bytes[start_at+k] = b;
                end
            end
            for (k = 0; k < text_len; k++) begin
                send_byte(text_bytes[k], k == text_len - 1, 1'b0, '0);
            end
        end

        allow_idle = 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard
    initial begin
        #TIMEOUT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== substring_search.f =====
design/ss_pkg.sv
design/ss_cell.sv
design/substring_search.sv
design/ss_checker.sv
tb/sv/substring_search_test.sv
